>>> rtl/iar_pkg.sv
// Shared types, reference colors and divider constants for the icon accent recolor block.
`default_nettype none

package iar_pkg;

  localparam int NumRef  = 4;
  localparam int NumChan = 3;

  typedef logic [7:0]  chan_t;
  typedef logic [15:0] sq_t;
  typedef logic [17:0] sq_sum_t;
  typedef logic [15:0] num_t;
  typedef logic [17:0] recip_t;
  typedef logic [33:0] prod_t;
  typedef logic [9:0]  quo_t;
  typedef logic [1:0]  ref_sel_t;
  typedef logic [1:0]  cfg_idx_t;

  // Reference luma selection
  localparam ref_sel_t REF_TURQ   = 2'd0;
  localparam ref_sel_t REF_ORANGE = 2'd1;
  localparam ref_sel_t REF_GOLD   = 2'd2;

  // Register indexes
  localparam cfg_idx_t REG_ACCENT_RED   = 2'd0;
  localparam cfg_idx_t REG_ACCENT_GREEN = 2'd1;
  localparam cfg_idx_t REG_ACCENT_BLUE  = 2'd2;

  localparam chan_t ACCENT_RED_RST   = 8'd0;
  localparam chan_t ACCENT_GREEN_RST = 8'd143;
  localparam chan_t ACCENT_BLUE_RST  = 8'd120;

  // Reference colors: orange, turquoise, bright turquoise, gold
  localparam chan_t REF_CH [NumRef][NumChan] = '{
    '{8'd248, 8'd101, 8'd27},
    '{8'd0,   8'd143, 8'd120},
    '{8'd0,   8'd212, 8'd187},
    '{8'd214, 8'd166, 8'd50}
  };

  localparam sq_sum_t LIMIT_SQ = 18'd2304;  // 48 squared

  localparam logic [6:0] LUMA_W_RED   = 7'd77;
  localparam logic [7:0] LUMA_W_GREEN = 8'd150;
  localparam logic [4:0] LUMA_W_BLUE  = 5'd29;
  localparam chan_t      GOLD_G_MIN   = 8'd130;

  localparam int LumaTurq   = 97;
  localparam int LumaOrange = 136;
  localparam int LumaGold   = 167;

  // Exact reciprocals for 16-bit dividends: ceil(2^24 / d)
  localparam int RecipShift = 24;
  localparam recip_t RECIP_TURQ   = recip_t'(((2**RecipShift) + LumaTurq - 1) / LumaTurq);
  localparam recip_t RECIP_ORANGE = recip_t'(((2**RecipShift) + LumaOrange - 1) / LumaOrange);
  localparam recip_t RECIP_GOLD   = recip_t'(((2**RecipShift) + LumaGold - 1) / LumaGold);

  localparam chan_t HALF_TURQ   = chan_t'(LumaTurq / 2);
  localparam chan_t HALF_ORANGE = chan_t'(LumaOrange / 2);
  localparam chan_t HALF_GOLD   = chan_t'(LumaGold / 2);

  localparam chan_t CHAN_MAX = 8'd255;

  function automatic chan_t ref_half(input ref_sel_t sel);
    chan_t h;
    unique case (sel)
      REF_GOLD:   h = HALF_GOLD;
      REF_ORANGE: h = HALF_ORANGE;
      default:    h = HALF_TURQ;
    endcase
    return h;
  endfunction

  function automatic recip_t ref_recip(input ref_sel_t sel);
    recip_t m;
    unique case (sel)
      REF_GOLD:   m = RECIP_GOLD;
      REF_ORANGE: m = RECIP_ORANGE;
      default:    m = RECIP_TURQ;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/iar_if.sv
// Pixel and result stream interfaces.
`default_nettype none

interface iar_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface iar_res_if;
  logic       valid;
  logic       ready;
  logic       is_accent;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, is_accent, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, is_accent, out_red, out_green, out_blue, output ready);
endinterface

`default_nettype wire

>>> rtl/icon_accent_recolor.sv
// Top level: icon accent detection and luma-scaled accent recolor.
// Throughput: one pixel per cycle while the result sink takes beats; four register stages
//   (differences/luma, squares/numerators, distance compare/reciprocal multiply,
//   clamp/output), each stage holds its beat while the one after it is full and stalled.
// Reset: synchronous, active low; clears all stage valid bits and loads accent defaults.
`default_nettype none

module icon_accent_recolor
  import iar_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  iar_pix_if.sink       in_pix,
  iar_res_if.source     out_res,
  input  wire logic     cfg_we,
  input  wire cfg_idx_t cfg_idx,
  input  wire chan_t    cfg_wdata
);

  // Accent registers
  chan_t accent_r [NumChan];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accent_r[0] <= ACCENT_RED_RST;
      accent_r[1] <= ACCENT_GREEN_RST;
      accent_r[2] <= ACCENT_BLUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ACCENT_RED:   accent_r[0] <= cfg_wdata;
        REG_ACCENT_GREEN: accent_r[1] <= cfg_wdata;
        REG_ACCENT_BLUE:  accent_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage enables
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic en1, en2, en3, en_out;

  assign en_out       = !out_v_r || out_res.ready;
  assign en3          = !s3_v_r || en_out;
  assign en2          = !s2_v_r || en3;
  assign en1          = !s1_v_r || en2;
  assign in_pix.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1)    s1_v_r  <= in_pix.valid;
      if (en2)    s2_v_r  <= s1_v_r;
      if (en3)    s3_v_r  <= s2_v_r;
      if (en_out) out_v_r <= s3_v_r;
    end
  end

  // Stage 1: per-reference absolute differences, luma, reference luma choice
  chan_t    pix_ch [NumChan];
  chan_t    s1_diff_nxt [NumRef][NumChan];
  chan_t    s1_diff_r   [NumRef][NumChan];
  logic [15:0] luma_sum;
  chan_t    s1_luma_r;
  ref_sel_t s1_sel_nxt, s1_sel_r;

  assign pix_ch[0] = in_pix.pixel_red;
  assign pix_ch[1] = in_pix.pixel_green;
  assign pix_ch[2] = in_pix.pixel_blue;

  always_comb begin
    for (int i = 0; i < NumRef; i++) begin
      for (int k = 0; k < NumChan; k++) begin
        s1_diff_nxt[i][k] = (pix_ch[k] > REF_CH[i][k]) ? (pix_ch[k] - REF_CH[i][k])
                                                       : (REF_CH[i][k] - pix_ch[k]);
      end
    end
  end

  assign luma_sum = 16'(16'(in_pix.pixel_red) * 16'(LUMA_W_RED))
                  + 16'(16'(in_pix.pixel_green) * 16'(LUMA_W_GREEN))
                  + 16'(16'(in_pix.pixel_blue) * 16'(LUMA_W_BLUE));

  always_comb begin
    priority if (in_pix.pixel_red > in_pix.pixel_green && in_pix.pixel_green > GOLD_G_MIN) begin
      s1_sel_nxt = REF_GOLD;
    end else if (in_pix.pixel_red > in_pix.pixel_green) begin
      s1_sel_nxt = REF_ORANGE;
    end else begin
      s1_sel_nxt = REF_TURQ;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_diff_r <= s1_diff_nxt;
      s1_luma_r <= luma_sum[15:8];
      s1_sel_r  <= s1_sel_nxt;
    end
  end

  // Stage 2: squared differences, rounded numerators
  sq_t      s2_sq_r  [NumRef][NumChan];
  num_t     s2_num_r [NumChan];
  ref_sel_t s2_sel_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < NumRef; i++) begin
        for (int k = 0; k < NumChan; k++) begin
          s2_sq_r[i][k] <= sq_t'(s1_diff_r[i][k]) * sq_t'(s1_diff_r[i][k]);
        end
      end
      for (int k = 0; k < NumChan; k++) begin
        s2_num_r[k] <= num_t'(num_t'(accent_r[k]) * num_t'(s1_luma_r))
                     + num_t'(ref_half(s1_sel_r));
      end
      s2_sel_r <= s1_sel_r;
    end
  end

  // Stage 3: distance compare, divide by reference luma through its reciprocal
  logic    s3_hit_nxt, s3_hit_r;
  sq_sum_t dist_sq [NumRef];
  recip_t  recip;
  prod_t   prod [NumChan];
  quo_t    s3_quo_r [NumChan];

  always_comb begin
    s3_hit_nxt = 1'b0;
    for (int i = 0; i < NumRef; i++) begin
      dist_sq[i] = sq_sum_t'(s2_sq_r[i][0]) + sq_sum_t'(s2_sq_r[i][1])
                 + sq_sum_t'(s2_sq_r[i][2]);
      s3_hit_nxt = s3_hit_nxt | (dist_sq[i] <= LIMIT_SQ);
    end
  end

  assign recip = ref_recip(s2_sel_r);

  always_comb begin
    for (int k = 0; k < NumChan; k++) begin
      prod[k] = prod_t'(s2_num_r[k]) * prod_t'(recip);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_hit_r <= s3_hit_nxt;
      for (int k = 0; k < NumChan; k++) begin
        s3_quo_r[k] <= prod[k][RecipShift +: 10];
      end
    end
  end

  // Stage 4: saturate and hold for the sink
  logic  is_accent_r;
  chan_t out_ch_r [NumChan];

  always_ff @(posedge clk) begin
    if (en_out) begin
      is_accent_r <= s3_hit_r;
      for (int k = 0; k < NumChan; k++) begin
        out_ch_r[k] <= (s3_quo_r[k] > quo_t'(CHAN_MAX)) ? CHAN_MAX : s3_quo_r[k][7:0];
      end
    end
  end

  assign out_res.valid     = out_v_r;
  assign out_res.is_accent = is_accent_r;
  assign out_res.out_red   = out_ch_r[0];
  assign out_res.out_green = out_ch_r[1];
  assign out_res.out_blue  = out_ch_r[2];

endmodule

`default_nettype wire

>>> rtl/iar_checker.sv
// Port-level assertions for the icon accent recolor block, with its bind.
`default_nettype none

module iar_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       is_accent,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(is_accent) && $stable(out_red)
                                   && $stable(out_green) && $stable(out_blue)))
    else $error("result beat changed while stalled");

  // A free-flowing sink never backs up the input
  a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input not ready while output drains");

  // Unstalled beat reaches the output after passing every stage register once it is taken
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_valid && in_ready, 4) && $past(rst_n, 4) && $past(rst_n, 3)
     && $past(rst_n, 2) && $past(rst_n, 1) && $past(out_ready, 3)
     && $past(out_ready, 2) && $past(out_ready, 1)) |-> out_valid)
    else $error("result beat missing after pipeline latency");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind icon_accent_recolor iar_checker u_iar_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .is_accent (out_res.is_accent),
  .out_red   (out_res.out_red),
  .out_green (out_res.out_green),
  .out_blue  (out_res.out_blue)
);

`default_nettype wire
